// File: hw/rtl/tnd_pkg.sv
// Shared constants, register codes and saturating helpers for the theta neuron derivative unit.
package tnd_pkg;

    localparam int unsigned CFG_INDEX_W = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXC_REVERSAL = 4'd0,
        CFG_INH_REVERSAL = 4'd1,
        CFG_EXC_SYN_TAU  = 4'd2,
        CFG_INH_SYN_TAU  = 4'd3
    } cfg_idx_t;

    // One in Q30, turns per radian scaled by 2^32, and pi scaled by 2^30.
    localparam logic [30:0]        Q30_ONE    = 31'h4000_0000;
    localparam logic signed [30:0] TURN_SCALE = 31'sd683565276;
    localparam logic signed [32:0] PI_Q30     = 33'sd3373259426;

    // Reciprocals for exact floor division of values below 2^30 by small constants.
    localparam int unsigned SH_42 = 36;
    localparam int unsigned SH_56 = 36;
    localparam int unsigned SH_20 = 35;
    localparam int unsigned SH_30 = 35;
    localparam int unsigned SH_6  = 33;
    localparam int unsigned SH_12 = 34;
    localparam logic [30:0] RC_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [30:0] RC_56 = 31'(((64'd1 << SH_56) + 64'd55) / 64'd56);
    localparam logic [30:0] RC_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [30:0] RC_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
    localparam logic [30:0] RC_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);
    localparam logic [30:0] RC_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);

    localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

    function automatic logic [29:0] div_const(input logic [29:0] v, input logic [30:0] m,
                                              input int unsigned sh);
        logic [60:0] p;
        p = {31'b0, v} * {30'b0, m};
        return 30'(p >> sh);
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? I64_MIN : I64_MAX;
        end
        return s[63:0];
    endfunction

    // Negation of a product that was first clamped to 64 bits.
    function automatic logic signed [63:0] neg_sat(input logic signed [65:0] p);
        logic signed [65:0] n;
        n = -p;
        if (p <= 66'(I64_MIN)) begin
            return I64_MAX;
        end
        if (p >= 66'(I64_MAX)) begin
            return -I64_MAX;
        end
        return n[63:0];
    endfunction

endpackage

// File: hw/rtl/tnd_div.sv
// Pipelined signed divider, one quotient bit per stage, saturating to 32 bits.
module tnd_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic        [30:0] den,
    output logic signed [31:0] quo
);

    localparam int STEPS = 32;

    logic [30:0] rem_reg  [STEPS+1];
    logic [30:0] rem_next [STEPS+1];
    logic [31:0] low_reg  [STEPS+1];
    logic [31:0] low_next [STEPS+1];
    logic [31:0] qt_reg   [STEPS+1];
    logic [31:0] qt_next  [STEPS+1];
    logic [30:0] den_reg  [STEPS+1];
    logic        neg_reg  [STEPS+1];
    logic        zero_reg [STEPS+1];
    logic        ovf_reg  [STEPS+1];

    logic [63:0]        mag;
    logic [31:0]        trial [STEPS+1];
    logic               ge    [STEPS+1];
    logic signed [31:0] quo_next;
    logic signed [31:0] quo_reg;

    always_comb
    begin
        mag = num[63] ? 64'(-num) : 64'(num);
        rem_next[0] = mag[62:32];
        low_next[0] = mag[31:0];
        qt_next[0]  = '0;
        trial[0]    = '0;
        ge[0]       = 1'b0;
        for (int k = 1; k <= STEPS; k++)
        begin
            trial[k]    = {rem_reg[k-1], low_reg[k-1][31]};
            ge[k]       = trial[k] >= {1'b0, den_reg[k-1]};
            rem_next[k] = ge[k] ? 31'(trial[k] - {1'b0, den_reg[k-1]}) : trial[k][30:0];
            low_next[k] = low_reg[k-1] << 1;
            qt_next[k]  = {qt_reg[k-1][30:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            low_reg[0]  <= low_next[0];
            qt_reg[0]   <= qt_next[0];
            den_reg[0]  <= den;
            neg_reg[0]  <= num[63];
            zero_reg[0] <= (mag == 64'd0);
            ovf_reg[0]  <= mag[63:32] >= {1'b0, den};
            for (int k = 1; k <= STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                qt_reg[k]   <= qt_next[k];
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
            quo_reg <= quo_next;
        end
    end

    // A quotient that does not fit in 32 bits, or a zero divisor, saturates by sign.
    always_comb
    begin
        if (zero_reg[STEPS])
        begin
            quo_next = '0;
        end
        else if (ovf_reg[STEPS])
        begin
            quo_next = neg_reg[STEPS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else if (!neg_reg[STEPS])
        begin
            quo_next = qt_reg[STEPS][31] ? 32'sh7FFF_FFFF : $signed(qt_reg[STEPS]);
        end
        else
        begin
            quo_next = (qt_reg[STEPS] > 32'h8000_0000) ? 32'sh8000_0000
                                                       : $signed(32'(-qt_reg[STEPS]));
        end
    end

    assign quo = quo_reg;

endmodule

// File: hw/rtl/theta_neuron_derivative.sv
// Theta neuron derivative unit: phase and drive derivatives in signed Q16.16.
// From an accepted request to its result, 16 stages compute the phase numerator and
// three 34-stage dividers produce the three quotients, one bit per step stage.
// Throughput is one request per cycle; a stalled result holds the whole pipeline in place.
// Reset clears the valid bits and loads the configuration registers with their defaults.
// The configuration port is always ready.
module theta_neuron_derivative (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic signed [31:0]              phase,
    input  logic signed [31:0]              exc_drive,
    input  logic signed [31:0]              inh_drive,
    input  logic signed [31:0]              applied_current,
    input  logic        [30:0]              cell_tau,
    input  logic                            last_in,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [31:0]              phase_rate,
    output logic signed [31:0]              exc_rate,
    output logic signed [31:0]              inh_rate,
    output logic                            last_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tnd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);

    import tnd_pkg::*;

    // Sixteen front stages plus the divider depth.
    localparam int LAT = 50;

    // Configuration registers. The user must change them only while the pipeline is empty,
    // which the block itself does not enforce; the stages read them directly.
    logic signed [31:0] exc_reversal_reg;
    logic signed [31:0] inh_reversal_reg;
    logic        [30:0] exc_syn_tau_reg;
    logic        [30:0] inh_syn_tau_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exc_reversal_reg <= 32'sd65536;
            inh_reversal_reg <= -32'sd65536;
            exc_syn_tau_reg  <= 31'd65536;
            inh_syn_tau_reg  <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_EXC_REVERSAL: exc_reversal_reg <= cfg_data;
                CFG_INH_REVERSAL: inh_reversal_reg <= cfg_data;
                CFG_EXC_SYN_TAU:  exc_syn_tau_reg  <= cfg_data[30:0];
                CFG_INH_SYN_TAU:  inh_syn_tau_reg  <= cfg_data[30:0];
                default:          ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished result is held by the receiver.
    logic adv;
    logic vld_reg  [LAT];
    logic last_reg [LAT];

    assign adv          = !(vld_reg[LAT-1] && result_stall);
    assign item_stall   = !adv;
    assign result_valid = vld_reg[LAT-1];
    assign last_out     = last_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Operand delay lines; entry k holds the value at stage k+1 (or k+2, k+3 where noted).
    logic signed [31:0] ie_dl  [16];
    logic signed [31:0] ii_dl  [16];
    logic signed [31:0] mu_dl  [10];
    logic        [30:0] tau_dl [16];
    logic signed [30:0] x_dl   [7];   // from stage 2
    logic        [1:0]  q_dl   [8];   // from stage 2
    logic        [29:0] x2_dl  [6];   // from stage 3

    // Stage registers of the sine, cosine and numerator datapath.
    logic        [31:0] u_reg;
    logic        [30:0] ts1_reg, tc1_reg, ts2_reg, tc2_reg, ts3_reg, tc3_reg;
    logic        [29:0] ps1_reg, pc1_reg, ps2_reg, pc2_reg, pc3_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] sn_reg, cs_reg, sn11_reg;
    logic signed [63:0] pe_reg, pi_reg, pm_reg;
    logic signed [34:0] base_reg;
    logic signed [33:0] ae_reg, ai_reg;
    logic signed [63:0] num0_reg, num0_13_reg, num0_14_reg;
    logic signed [65:0] me_reg, mi_reg;
    logic signed [63:0] te_reg, ti_reg, ti15_reg, n1_reg, num_reg;

    // Stage 1: phase to turns.
    logic signed [62:0] u_prod;
    assign u_prod = phase * TURN_SCALE;

    // Stage 2: nearest quarter turn off, remainder to Q30 radians.
    logic        [31:0] u_rnd;
    logic        [1:0]  q_next;
    logic        [31:0] f_wrap;
    logic signed [62:0] x_prod;
    assign u_rnd  = u_reg + 32'h2000_0000;
    assign q_next = u_rnd[31:30];
    assign f_wrap = u_reg - {q_next, 30'b0};
    assign x_prod = $signed(f_wrap[29:0]) * PI_Q30;

    // Stage 3: the square of the reduced angle.
    logic signed [61:0] xx_prod;
    assign xx_prod = x_dl[0] * x_dl[0];

    // Odd stages multiply by x squared (sine's last by x); even ones take the Horner step.
    logic [60:0] ps1_prod, pc1_prod, ps2_prod, pc2_prod, pc3_prod;
    assign ps1_prod = {31'b0, x2_dl[1]} * {30'b0, ts1_reg};
    assign pc1_prod = {31'b0, x2_dl[1]} * {30'b0, tc1_reg};
    assign ps2_prod = {31'b0, x2_dl[3]} * {30'b0, ts2_reg};
    assign pc2_prod = {31'b0, x2_dl[3]} * {30'b0, tc2_reg};
    assign pc3_prod = {31'b0, x2_dl[5]} * {30'b0, tc3_reg};

    logic signed [62:0] s_prod;
    assign s_prod = x_dl[6] * $signed({1'b0, ts3_reg});

    // Stage 10: finish the cosine and rotate by the quadrant.
    logic        [30:0] c_val;
    logic signed [31:0] c_s;
    logic signed [31:0] sn_next, cs_next;
    assign c_val = Q30_ONE - {1'b0, pc3_reg[29:1]};
    assign c_s   = $signed({1'b0, c_val});

    always_comb
    begin
        case (q_dl[7])
            2'd0:    begin sn_next = s_reg; cs_next = c_s;    end
            2'd1:    begin sn_next = c_s;   cs_next = -s_reg; end
            2'd2:    begin sn_next = -s_reg; cs_next = -c_s;  end
            default: begin sn_next = -c_s;  cs_next = s_reg;  end
        endcase
    end

    // Stage 11: products with one plus cosine.
    logic signed [32:0] opc;
    logic signed [34:0] base_next;
    assign opc       = 33'(cs_reg) + $signed({2'b0, Q30_ONE});
    assign base_next = (35'(signed'({1'b0, Q30_ONE})) - 35'(cs_reg)) <<< 2;

    // Stage 12: synaptic coefficients and the leak and current terms.
    logic signed [63:0] sn_shift;
    logic signed [63:0] diff_e, diff_i;
    assign sn_shift = 64'(sn11_reg) <<< 16;
    assign diff_e   = sn_shift - pe_reg;
    assign diff_i   = sn_shift - pi_reg;

    // Dividends for the drive derivatives: the drive in Q32, negated at the divider input.
    logic signed [63:0] ie_q32, ii_q32;
    assign ie_q32 = {{16{ie_dl[15][31]}}, ie_dl[15], 16'h0};
    assign ii_q32 = {{16{ii_dl[15][31]}}, ii_dl[15], 16'h0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg[0] <= last_in;
            for (int k = 1; k < LAT; k++)
            begin
                last_reg[k] <= last_reg[k-1];
            end

            ie_dl[0]  <= exc_drive;
            ii_dl[0]  <= inh_drive;
            tau_dl[0] <= cell_tau;
            for (int k = 1; k < 16; k++)
            begin
                ie_dl[k]  <= ie_dl[k-1];
                ii_dl[k]  <= ii_dl[k-1];
                tau_dl[k] <= tau_dl[k-1];
            end
            mu_dl[0] <= applied_current;
            for (int k = 1; k < 10; k++)
            begin
                mu_dl[k] <= mu_dl[k-1];
            end

            // Angle reduction.
            u_reg    <= u_prod[47:16];
            x_dl[0]  <= x_prod[61:31];
            q_dl[0]  <= q_next;
            for (int k = 1; k < 7; k++)
            begin
                x_dl[k] <= x_dl[k-1];
            end
            for (int k = 1; k < 8; k++)
            begin
                q_dl[k] <= q_dl[k-1];
            end
            x2_dl[0] <= xx_prod[59:30];
            for (int k = 1; k < 6; k++)
            begin
                x2_dl[k] <= x2_dl[k-1];
            end

            // Horner chains for sine and cosine.
            ts1_reg <= Q30_ONE - {1'b0, div_const(x2_dl[0], RC_42, SH_42)};
            tc1_reg <= Q30_ONE - {1'b0, div_const(x2_dl[0], RC_56, SH_56)};
            ps1_reg <= ps1_prod[59:30];
            pc1_reg <= pc1_prod[59:30];
            ts2_reg <= Q30_ONE - {1'b0, div_const(ps1_reg, RC_20, SH_20)};
            tc2_reg <= Q30_ONE - {1'b0, div_const(pc1_reg, RC_30, SH_30)};
            ps2_reg <= ps2_prod[59:30];
            pc2_reg <= pc2_prod[59:30];
            ts3_reg <= Q30_ONE - {1'b0, div_const(ps2_reg, RC_6, SH_6)};
            tc3_reg <= Q30_ONE - {1'b0, div_const(pc2_reg, RC_12, SH_12)};
            s_reg   <= s_prod[61:30];
            pc3_reg <= pc3_prod[59:30];
            sn_reg  <= sn_next;
            cs_reg  <= cs_next;

            // Phase numerator in Q32.
            sn11_reg    <= sn_reg;
            pe_reg      <= exc_reversal_reg * opc;
            pi_reg      <= inh_reversal_reg * opc;
            pm_reg      <= mu_dl[9] * opc;
            base_reg    <= base_next;
            ae_reg      <= diff_e[63:30];
            ai_reg      <= diff_i[63:30];
            num0_reg    <= 64'(base_reg) + (pm_reg >>> 14);
            me_reg      <= ae_reg * ie_dl[11];
            mi_reg      <= ai_reg * ii_dl[11];
            num0_13_reg <= num0_reg;
            te_reg      <= neg_sat(me_reg);
            ti_reg      <= neg_sat(mi_reg);
            num0_14_reg <= num0_13_reg;
            n1_reg      <= add_sat(num0_14_reg, te_reg);
            ti15_reg    <= ti_reg;
            num_reg     <= add_sat(n1_reg, ti15_reg);
        end
    end

    // Three dividers run side by side on stage 16 operands.
    tnd_div u_div_phase (
        .clk (clk),
        .en  (adv),
        .num (num_reg),
        .den (tau_dl[15]),
        .quo (phase_rate)
    );

    tnd_div u_div_exc (
        .clk (clk),
        .en  (adv),
        .num (-ie_q32),
        .den (exc_syn_tau_reg),
        .quo (exc_rate)
    );

    tnd_div u_div_inh (
        .clk (clk),
        .en  (adv),
        .num (-ii_q32),
        .den (inh_syn_tau_reg),
        .quo (inh_rate)
    );

endmodule

// File: tb/tb_theta_neuron_derivative.sv
// Self-checking testbench for the theta neuron derivative unit.
module tb_theta_neuron_derivative;
    import tnd_pkg::*;

    // One neuron as it enters the unit, and the three derivatives it comes back with.
    typedef struct packed {
        logic signed [31:0] phase;
        logic signed [31:0] exc_drive;
        logic signed [31:0] inh_drive;
        logic signed [31:0] applied_current;
        logic        [30:0] cell_tau;
        logic               last;
    } neuron_t;

    typedef struct packed {
        logic signed [31:0] phase_rate;
        logic signed [31:0] exc_rate;
        logic signed [31:0] inh_rate;
        logic               last;
    } rates_t;

    // A row of the directed table; known rows carry a result typed in by hand.
    typedef struct {
        neuron_t n;
        bit      known;
        rates_t  r;
    } vector_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 4'd9;
    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint TURNS_RAD = 64'sd683565276;
    localparam longint PI_RAD    = 64'sd3373259426;
    localparam longint S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 160;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic signed [31:0] phase;
    logic signed [31:0] exc_drive;
    logic signed [31:0] inh_drive;
    logic signed [31:0] applied_current;
    logic [30:0] cell_tau;
    logic last_in;
    logic result_valid;
    logic result_stall;
    logic signed [31:0] phase_rate;
    logic signed [31:0] exc_rate;
    logic signed [31:0] inh_rate;
    logic last_out;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    theta_neuron_derivative dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .phase(phase), .exc_drive(exc_drive), .inh_drive(inh_drive),
        .applied_current(applied_current), .cell_tau(cell_tau), .last_in(last_in),
        .result_valid(result_valid), .result_stall(result_stall),
        .phase_rate(phase_rate), .exc_rate(exc_rate), .inh_rate(inh_rate),
        .last_out(last_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Our own copy of the configuration registers, updated on every accepted write.
    logic signed [31:0] exc_reversal_m;
    logic signed [31:0] inh_reversal_m;
    logic [30:0] exc_syn_tau_m;
    logic [30:0] inh_syn_tau_m;

    rates_t expected_rates[$];
    int errors;
    bit long_hold;   // raised by the sender to ask the receiver for a long hold-off

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Saturating arithmetic on wide products, as the unit clamps the products and sums of its numerator.
    function automatic longint clamp64(input logic signed [127:0] v);
        if (v > S64_MAX) return S64_MAX;
        if (v < S64_MIN) return S64_MIN;
        return longint'(v);
    endfunction

    function automatic longint sum_sat(input longint a, input longint b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return clamp64(wa + wb);
    endfunction

    // Negated saturated product; a product pinned at the most negative value flips to the
    // most positive one.
    function automatic longint neg_prod_sat(input longint a, input longint b);
        logic signed [127:0] wa, wb;
        longint p;
        wa = a;
        wb = b;
        p = clamp64(wa * wb);
        return (p == S64_MIN) ? S64_MAX : -p;
    endfunction

    // Quotient truncated toward zero and clamped to 32 bits; a zero divisor gives the
    // clamped value that carries the sign of the dividend.
    function automatic logic signed [31:0] quot_sat(input longint num, input longint den);
        longint qv;
        if (den == 0) return (num > 0) ? S32_MAX : ((num < 0) ? S32_MIN : 32'sd0);
        qv = num / den;
        if (qv > longint'(S32_MAX)) return S32_MAX;
        if (qv < longint'(S32_MIN)) return S32_MIN;
        return 32'(qv);
    endfunction

    function automatic rates_t predict_rates(input neuron_t n);
        logic [63:0] prod, turns, quad;
        logic signed [31:0] frac;
        longint x, x2, t, s, c, sn, cs, opc, ae, ai, num, ee, ei, ie, ii, mu;
        rates_t r;
        ee = exc_reversal_m;
        ei = inh_reversal_m;
        ie = n.exc_drive;
        ii = n.inh_drive;
        mu = n.applied_current;

        // Phase in turns as a 32 bit fraction, then reduce to the nearest quarter turn.
        prod = $unsigned(longint'(n.phase)) * $unsigned(TURNS_RAD);
        turns = (prod >> 16) & 64'hFFFF_FFFF;
        quad = ((turns + 64'h2000_0000) >> 30) & 64'd3;
        frac = 32'(turns - (quad << 30));
        x = (longint'(frac) * PI_RAD) >>> 31;
        x2 = (x * x) >>> 30;

        t = ONE_Q30 - x2 / 42;
        t = ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t = ONE_Q30 - ((x2 * t) >>> 30) / 6;
        s = (x * t) >>> 30;

        t = ONE_Q30 - x2 / 56;
        t = ONE_Q30 - ((x2 * t) >>> 30) / 30;
        t = ONE_Q30 - ((x2 * t) >>> 30) / 12;
        c = ONE_Q30 - ((x2 * t) >>> 30) / 2;

        case (quad[1:0])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase

        opc = ONE_Q30 + cs;
        ae = (sn * 65536 - ee * opc) >>> 30;
        ai = (sn * 65536 - ei * opc) >>> 30;

        num = (ONE_Q30 - cs) * 4;
        num = sum_sat(num, (mu * opc) >>> 14);
        num = sum_sat(num, neg_prod_sat(ae, ie));
        num = sum_sat(num, neg_prod_sat(ai, ii));

        r.phase_rate = quot_sat(num, longint'(n.cell_tau));
        r.exc_rate   = quot_sat(-(ie * 65536), longint'(exc_syn_tau_m));
        r.inh_rate   = quot_sat(-(ii * 65536), longint'(inh_syn_tau_m));
        r.last       = n.last;
        return r;
    endfunction

    // Offers one request and holds it until the unit takes it. The expected derivatives
    // are queued at the accepting edge; a known row supplies its own.
    task automatic send_neuron(input neuron_t n, input bit known, input rates_t r);
        item_valid      <= 1'b1;
        phase           <= n.phase;
        exc_drive       <= n.exc_drive;
        inh_drive       <= n.inh_drive;
        applied_current <= n.applied_current;
        cell_tau        <= n.cell_tau;
        last_in         <= n.last;
        do @(posedge clk); while (item_stall);
        expected_rates.push_back(known ? r : predict_rates(n));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EXC_REVERSAL: exc_reversal_m = value;
            CFG_INH_REVERSAL: inh_reversal_m = value;
            CFG_EXC_SYN_TAU:  exc_syn_tau_m  = value[30:0];
            CFG_INH_SYN_TAU:  inh_syn_tau_m  = value[30:0];
            default: ;
        endcase
    endtask

    // Waits until every queued result has come back, then lets the pipeline settle.
    task automatic drain();
        while (expected_rates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q16(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(0, 256)) - 128);
            default: return ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
        endcase
    endfunction

    // Mostly realistic neurons (small phases and drives, taus of a few ms), with a
    // share of full-range words, extremes and zero cell time constants.
    function automatic neuron_t random_neuron();
        neuron_t n;
        int sel;
        sel = $urandom_range(0, 9);
        n.phase           = rand_q16(sel < 5 ? 1 : (sel < 8 ? 0 : $urandom_range(0, 3)));
        n.exc_drive       = rand_q16(sel < 5 ? 1 : $urandom_range(0, 3));
        n.inh_drive       = rand_q16(sel < 5 ? 1 : $urandom_range(0, 3));
        n.applied_current = rand_q16(sel < 5 ? 1 : $urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: n.cell_tau = '0;
            1: n.cell_tau = 31'($urandom_range(1, 4));
            2: n.cell_tau = '1;
            3, 4: n.cell_tau = 31'($urandom());
            default: n.cell_tau = 31'($urandom_range(1 << 14, 40 << 16));
        endcase
        n.last = $urandom_range(0, 1);
        return n;
    endfunction

    // The receiver stalls in patterns that it changes at random, and honors a
    // request for one long hold-off so that the pipeline backs up to the input.
    initial begin : receiver
        int pattern;
        int span;
        int k;
        result_stall = 1'b0;
        pattern = 0;
        span = 0;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                result_stall <= 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
                long_hold = 1'b0;
            end
            if (span == 0) begin
                pattern = $urandom_range(0, 3);
                span = $urandom_range(10, 80);
            end
            span--;
            case (pattern)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= ~result_stall;
            endcase
        end
    end

    // Each result taken from the unit is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (expected_rates.size() == 0) begin
                $display("%0t: result with none expected: %h %h %h %b", $time,
                         phase_rate, exc_rate, inh_rate, last_out);
                errors++;
            end else begin
                rates_t want;
                want = expected_rates.pop_front();
                if (phase_rate !== want.phase_rate) begin
                    $display("%0t: phase_rate expected %h actual %h", $time,
                             want.phase_rate, phase_rate);
                    errors++;
                end
                if (exc_rate !== want.exc_rate) begin
                    $display("%0t: exc_rate expected %h actual %h", $time,
                             want.exc_rate, exc_rate);
                    errors++;
                end
                if (inh_rate !== want.inh_rate) begin
                    $display("%0t: inh_rate expected %h actual %h", $time,
                             want.inh_rate, inh_rate);
                    errors++;
                end
                if (last_out !== want.last) begin
                    $display("%0t: last_out expected %b actual %b", $time,
                             want.last, last_out);
                    errors++;
                end
            end
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("tb_theta_neuron_derivative: errors");
                $finish;
            end
        end
    end

    vector_t vectors[$];

    function automatic vector_t vec(input logic [31:0] ph, input logic [31:0] ie,
                                    input logic [31:0] ii, input logic [31:0] mu,
                                    input logic [30:0] tau, input logic last,
                                    input bit known, input rates_t r);
        vector_t v;
        v.n = '{ph, ie, ii, mu, tau, last};
        v.known = known;
        v.r = r;
        return v;
    endfunction

    initial begin : stimulus
        localparam logic [31:0] ONE = 32'h0001_0000;
        rates_t none;
        neuron_t n;
        int phase_no, i, burst, gap;
        none = '0;
        errors = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        phase = '0;
        exc_drive = '0;
        inh_drive = '0;
        applied_current = '0;
        cell_tau = '0;
        last_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        exc_reversal_m = 32'sd65536;
        inh_reversal_m = -32'sd65536;
        exc_syn_tau_m = 31'd65536;
        inh_syn_tau_m = 31'd65536;

        // Directed rows with reset registers. At phase zero sin is 0 and cos is 1, so the
        // known rows follow directly from the formula.
        vectors.push_back(vec(0, 0, 0, 0, ONE, 0, 1, '{0, 0, 0, 0}));
        vectors.push_back(vec(0, 0, 0, ONE, ONE, 1, 1, '{131072, 0, 0, 1}));
        vectors.push_back(vec(0, 0, 0, ONE, 0, 0, 1, '{S32_MAX, 0, 0, 0}));
        vectors.push_back(vec(0, 0, 0, -ONE, 0, 0, 1, '{S32_MIN, 0, 0, 0}));
        vectors.push_back(vec(0, 0, 0, 0, 0, 1, 1, '{0, 0, 0, 1}));
        vectors.push_back(vec(0, ONE, 0, 0, ONE, 0, 1, '{131072, -65536, 0, 0}));
        vectors.push_back(vec(0, 0, ONE, 0, ONE, 0, 1, '{-131072, 0, -65536, 0}));
        vectors.push_back(vec(0, S32_MIN, 0, 0, ONE, 0, 0, none));
        vectors.push_back(vec(0, 0, S32_MIN, 0, ONE, 0, 0, none));
        vectors.push_back(vec(0, S32_MAX, S32_MAX, 0, '1, 1, 0, none));
        vectors.push_back(vec(S32_MAX, 0, 0, ONE, ONE, 0, 0, none));
        vectors.push_back(vec(S32_MIN, ONE, -ONE, ONE, ONE, 0, 0, none));
        vectors.push_back(vec(32'd102944, ONE, ONE, 0, ONE, 0, 0, none));
        vectors.push_back(vec(32'd205887, ONE, ONE, ONE, ONE, 0, 0, none));
        vectors.push_back(vec(-32'd102944, ONE, ONE, -ONE, ONE, 1, 0, none));
        vectors.push_back(vec(32'd51472, S32_MAX, S32_MIN, S32_MAX, 1, 0, 0, none));
        vectors.push_back(vec(32'd411775, S32_MIN, S32_MAX, S32_MIN, 1, 1, 0, none));
        vectors.push_back(vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              '1, 1, 0, none));
        vectors.push_back(vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                              31'h2AAA_AAAA, 0, 0, none));
        vectors.push_back(vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                              31'h5555_5555, 1, 0, none));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[k]) begin
            send_neuron(vectors[k].n, vectors[k].known, vectors[k].r);
            if ($urandom_range(0, 2) == 0) begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
        item_valid <= 1'b0;

        // Random phases, each under its own register setting; extremes come first.
        for (phase_no = 0; phase_no < 5; phase_no++) begin
            drain();
            case (phase_no)
                0: begin
                    write_reg(CFG_EXC_REVERSAL, S32_MAX);
                    write_reg(CFG_INH_REVERSAL, S32_MIN);
                    write_reg(CFG_EXC_SYN_TAU, 32'd1);
                    write_reg(CFG_INH_SYN_TAU, 32'd1);
                end
                1: begin
                    write_reg(CFG_EXC_REVERSAL, S32_MIN);
                    write_reg(CFG_INH_REVERSAL, S32_MAX);
                    write_reg(CFG_EXC_SYN_TAU, 32'h7FFF_FFFF);
                    write_reg(CFG_INH_SYN_TAU, 32'h7FFF_FFFF);
                end
                2: begin
                    write_reg(CFG_EXC_REVERSAL, 32'd0);
                    write_reg(CFG_INH_REVERSAL, 32'd0);
                    write_reg(CFG_EXC_SYN_TAU, $urandom_range(1, 32'h7FFF_FFFF));
                    write_reg(CFG_INH_SYN_TAU, $urandom_range(1 << 16, 20 << 16));
                end
                3: begin
                    write_reg(CFG_EXC_REVERSAL, $urandom());
                    write_reg(CFG_INH_REVERSAL, rand_q16(1));
                    write_reg(CFG_EXC_SYN_TAU, $urandom_range(1 << 16, 20 << 16));
                    write_reg(CFG_INH_SYN_TAU, $urandom_range(1, 32'h7FFF_FFFF));
                end
                default: begin
                    // Realistic reversal potentials, plus a write to an unused index
                    // that must leave every register alone.
                    write_reg(CFG_EXC_REVERSAL, ONE);
                    write_reg(CFG_INH_REVERSAL, -ONE);
                    write_reg(CFG_EXC_SYN_TAU, 32'h0005_0000);
                    write_reg(CFG_INH_SYN_TAU, 32'h000A_0000);
                    write_reg(CFG_UNUSED, 32'h0000_0001);
                end
            endcase

            burst = $urandom_range(1, 40);
            for (i = 0; i < 190; i++) begin
                n = random_neuron();
                // Partway through one phase the receiver holds off while we keep
                // offering back to back, so the pipeline fills and stalls its input.
                if (phase_no == 2 && i == 60) long_hold = 1'b1;
                send_neuron(n, 0, none);
                if (long_hold) continue;
                burst--;
                if (burst == 0) begin
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 4);
                    if (gap != 0) begin
                        item_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst = $urandom_range(1, 60);
                end
            end
            item_valid <= 1'b0;
        end

        drain();
        if (errors == 0 && expected_rates.size() == 0)
            $display("tb_theta_neuron_derivative: clean");
        else
            $display("tb_theta_neuron_derivative: errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tnd_pkg.sv
hw/rtl/tnd_div.sv
hw/rtl/theta_neuron_derivative.sv
tb/tb_theta_neuron_derivative.sv
